// ===== src/stgf_pkg.sv =====
// ----------------------------------------------------------------------------
// stgf_pkg
// Shared widths, reset values, codes and types of the sine tone generator.
// ----------------------------------------------------------------------------
package stgf_pkg;

  localparam int unsigned INDEX_WIDTH_DEF = 22;

  localparam int unsigned RATE_W     = 16;
  localparam int unsigned PEAK_W     = 15;
  localparam int unsigned FREQ_W     = 15;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FADE_W     = 8;
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned SINE_W     = 15;
  localparam int unsigned ENV_W      = 16;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd22050;
  localparam logic [PEAK_W-1:0] PEAK_RESET = 15'd28000;

  localparam int unsigned MS_PER_S = 1000;
  // fade lasts 5 ms of samples
  localparam int unsigned FADE_DIV = 200;

  // shared divider: 48-bit dividend, 16-bit divisor, 4 quotient bits a cycle
  localparam int unsigned DIV_W     = 48;
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned DIV_RADIX = 4;

  localparam int unsigned MUL_W = 32;

  localparam int unsigned QUEUE_DEPTH = 2;

  // sine polynomial, Q30 coefficients of an odd series over a quarter turn
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569306;
  localparam logic [31:0] C7 = 32'd5026995;
  localparam logic [31:0] C9 = 32'd172272;
  localparam int unsigned POLY_TERMS = 4;

  typedef enum logic {
    REG_SAMPLE_RATE    = 1'b0,
    REG_PEAK_AMPLITUDE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_W-1:0]     quotient;
    logic [DIVISOR_W-1:0] remainder;
  } div_rsp_t;

  // horner coefficients after c9, in order of use
  function automatic logic [31:0] poly_coef(input logic [1:0] k);
    logic [31:0] c;
    case (k)
      2'd0:    c = C7;
      2'd1:    c = C5;
      2'd2:    c = C3;
      2'd3:    c = C1;
      default: c = C1;
    endcase
    return c;
  endfunction

endpackage

// ===== src/sine_tone_generator_with_fade_top.sv =====
// ----------------------------------------------------------------------------
// sine_tone_generator_with_fade_top
// Sequencing: a silent tick goes straight to the output word; a playing tick
// runs through the shared 4-bit-per-cycle divider and the shared registered
// multiplier, and a start tick first sets up the tone on the same two units.
// Throughput: one tick at a time in the sample engine; a 2-word queue and the
// output register let input and output stall on their own.
// Reset: asynchronous; idle, no tone, rate 22050 and peak 28000.
// ----------------------------------------------------------------------------
module sine_tone_generator_with_fade_top #(
  parameter int unsigned INDEX_WIDTH = stgf_pkg::INDEX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  stgf_pkg::cfg_reg_e                   cfg_index_i,
  input  logic [stgf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 start_req_i,
  input  logic [stgf_pkg::FREQ_W-1:0]          freq_hz_i,
  input  logic [stgf_pkg::DUR_W-1:0]           duration_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [stgf_pkg::SAMPLE_W-1:0] sample_o,
  output logic                                 active_o,
  output logic                                 last_o
);
  import stgf_pkg::*;

  logic     q_valid, q_pop;
  item_t    q_item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready_o = 1'b1;

  stgf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_req_i   (start_req_i),
    .freq_hz_i     (freq_hz_i),
    .duration_ms_i (duration_ms_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  stgf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  stgf_back #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o),
    .active_o    (active_o),
    .last_o      (last_o)
  );

endmodule

// ===== src/stgf_front.sv =====
// ----------------------------------------------------------------------------
// stgf_front
// Input side: takes tick words, tags start requests and queues them.
// ----------------------------------------------------------------------------
module stgf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         start_req_i,
  input  logic [stgf_pkg::FREQ_W-1:0]  freq_hz_i,
  input  logic [stgf_pkg::DUR_W-1:0]   duration_ms_i,
  output logic                         q_valid_o,
  output stgf_pkg::item_t              q_item_o,
  input  logic                         q_pop_i
);
  import stgf_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_q [QUEUE_DEPTH];
  item_t            item_in;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  // tone fields only matter on a start word
  always_comb begin
    item_in.start = start_req_i;
    item_in.freq  = start_req_i ? freq_hz_i : '0;
    item_in.dur   = start_req_i ? duration_ms_i : '0;
  end

  assign in_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_pop_i & q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> (count_q != '0))
    else $error("pop from empty queue");

  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
    else $error("queue count missed a push");

endmodule

// ===== src/stgf_div.sv =====
// ----------------------------------------------------------------------------
// stgf_div
// Shared iterative restoring divider, a few quotient bits per cycle.
// ----------------------------------------------------------------------------
module stgf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stgf_pkg::div_req_t  req_i,
  output stgf_pkg::div_rsp_t  rsp_o
);
  import stgf_pkg::*;

  localparam int unsigned STEPS = DIV_W / DIV_RADIX;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [DIV_W-1:0]     quo_q, quo_w;
  logic [DIVISOR_W-1:0] den_q, rem_q, rem_w;
  logic [DIVISOR_W:0]   rem_x;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;

  always_comb begin
    rem_w = rem_q;
    quo_w = quo_q;
    rem_x = '0;
    for (int i = 0; i < DIV_RADIX; i++) begin
      rem_x = {rem_w, quo_w[DIV_W-1]};
      quo_w = {quo_w[DIV_W-2:0], 1'b0};
      if (rem_x >= {1'b0, den_q}) begin
        rem_x    = rem_x - {1'b0, den_q};
        quo_w[0] = 1'b1;
      end
      rem_w = rem_x[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(STEPS);
    end else if (busy_q && cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      quo_q <= quo_w;
      rem_q <= rem_w;
    end
  end

  assign rsp_o.done      = busy_q & (cnt_q == '0);
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> (busy_q && cnt_q == CNT_W'(STEPS)))
    else $error("divider did not load");

  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q != '0) |=> busy_q)
    else $error("divider dropped busy mid-run");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.done && den_q != '0) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

endmodule

// ===== src/stgf_back.sv =====
// ----------------------------------------------------------------------------
// stgf_back
// Sample engine: tone setup, phase to angle, sine polynomial, envelope,
// scaling and the output word register.
// ----------------------------------------------------------------------------
module stgf_back #(
  parameter int unsigned INDEX_WIDTH = stgf_pkg::INDEX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  stgf_pkg::cfg_reg_e                   cfg_index_i,
  input  logic [stgf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 q_valid_i,
  input  stgf_pkg::item_t                      q_item_i,
  output logic                                 q_pop_o,
  output stgf_pkg::div_req_t                   div_req_o,
  input  stgf_pkg::div_rsp_t                   div_rsp_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [stgf_pkg::SAMPLE_W-1:0] sample_o,
  output logic                                 active_o,
  output logic                                 last_o
);
  import stgf_pkg::*;

  localparam int unsigned IW = INDEX_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_LEN_MUL,
    ST_LEN_DIV,
    ST_FADE_DIV,
    ST_STEP_DIV,
    ST_ANG_DIV,
    ST_SQ_MUL,
    ST_POLY_MUL,
    ST_Y_MUL,
    ST_ENV_DIV,
    ST_AMP_MUL,
    ST_MAG_MUL,
    ST_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic                ph_q, ph_d;
  logic [RATE_W-1:0]   rate_q, rate_d;
  logic [PEAK_W-1:0]   peak_q, peak_d;
  item_t               item_q, item_d;
  logic [IW-1:0]       idx_q, idx_d, tone_q, tone_d;
  logic [FADE_W-1:0]   fade_q, fade_d;
  logic [PHASE_W-1:0]  acc_q, acc_d, step_q, step_d;
  logic                playing_q, playing_d;
  logic [30:0]         x_q, x_d, x2_q, x2_d;
  logic                neg_q, neg_d;
  logic [31:0]         t_q, t_d;
  logic [1:0]          k_q, k_d;
  logic [SINE_W-1:0]   s_q, s_d;
  logic [ENV_W-1:0]    env_q, env_d;
  logic [29:0]         p1_q, p1_d;
  logic [SAMPLE_W-1:0] res_sample_q, res_sample_d;
  logic                res_active_q, res_active_d, res_last_q, res_last_d;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_sample_q, out_sample_d;
  logic                out_active_q, out_active_d, out_last_q, out_last_d;

  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [2*MUL_W-1:0]  prod_q;

  logic [31:0]         angle;
  logic [IW:0]         idx_inc;
  logic                last_w;
  logic [PHASE_W:0]    acc_sum, acc_wrap;
  logic [IW-1:0]       fall_start, env_num;
  logic                rise_w, fall_w;
  logic [SINE_W-1:0]   mag;

  assign angle      = (rate_q == '0) ? '0 : div_rsp_i.quotient[31:0];
  assign idx_inc    = {1'b0, idx_q} + 1'b1;
  assign last_w     = (idx_inc >= {1'b0, tone_q});
  assign acc_sum    = {1'b0, acc_q} + {1'b0, step_q};
  assign acc_wrap   = acc_sum - {1'b0, rate_q};
  assign fall_start = tone_q - IW'(fade_q);
  assign rise_w     = (idx_q < IW'(fade_q));
  assign fall_w     = (tone_q >= IW'(fade_q)) && (idx_q > fall_start);
  // the falling edge wins where both ramps apply
  assign env_num    = fall_w ? (tone_q - idx_q) : idx_q;
  assign mag        = prod_q[45:31];

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    state_d      = state_q;
    ph_d         = ph_q;
    rate_d       = rate_q;
    peak_d       = peak_q;
    item_d       = item_q;
    idx_d        = idx_q;
    tone_d       = tone_q;
    fade_d       = fade_q;
    acc_d        = acc_q;
    step_d       = step_q;
    playing_d    = playing_q;
    x_d          = x_q;
    x2_d         = x2_q;
    neg_d        = neg_q;
    t_d          = t_q;
    k_d          = k_q;
    s_d          = s_q;
    env_d        = env_q;
    p1_d         = p1_q;
    res_sample_d = res_sample_q;
    res_active_d = res_active_q;
    res_last_d   = res_last_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_sample_d = out_sample_q;
    out_active_d = out_active_q;
    out_last_d   = out_last_q;
    mul_a        = '0;
    mul_b        = '0;
    div_req_o    = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SAMPLE_RATE:    rate_d = cfg_data_i[RATE_W-1:0];
        REG_PEAK_AMPLITUDE: peak_d = cfg_data_i[PEAK_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          item_d  = q_item_i;
          state_d = q_item_i.start ? ST_LEN_MUL : ST_TICK;
        end
      end

      ST_LEN_MUL: begin
        mul_a = MUL_W'(rate_q);
        mul_b = MUL_W'(item_q.dur);
        ph_d  = ~ph_q;
        if (ph_q) begin
          state_d = ST_LEN_DIV;
        end
      end

      ST_LEN_DIV: begin
        div_req_o.dividend = DIV_W'(prod_q[31:0]);
        div_req_o.divisor  = DIVISOR_W'(MS_PER_S);
        if (!ph_q) begin
          div_req_o.start = 1'b1;
          ph_d            = 1'b1;
        end else if (div_rsp_i.done) begin
          tone_d    = (div_rsp_i.quotient[DIV_W-1:IW] != '0) ? '1
                                                             : div_rsp_i.quotient[IW-1:0];
          playing_d = (tone_d != '0);
          ph_d      = 1'b0;
          state_d   = ST_FADE_DIV;
        end
      end

      ST_FADE_DIV: begin
        div_req_o.dividend = DIV_W'(rate_q);
        div_req_o.divisor  = DIVISOR_W'(FADE_DIV);
        if (!ph_q) begin
          div_req_o.start = 1'b1;
          ph_d            = 1'b1;
        end else if (div_rsp_i.done) begin
          fade_d  = (div_rsp_i.quotient[DIV_W-1:FADE_W] != '0) ? '1
                                                               : div_rsp_i.quotient[FADE_W-1:0];
          ph_d    = 1'b0;
          state_d = ST_STEP_DIV;
        end
      end

      ST_STEP_DIV: begin
        div_req_o.dividend = DIV_W'(item_q.freq);
        div_req_o.divisor  = rate_q;
        if (!ph_q) begin
          div_req_o.start = 1'b1;
          ph_d            = 1'b1;
        end else if (div_rsp_i.done) begin
          step_d  = (rate_q == '0) ? '0 : div_rsp_i.remainder;
          idx_d   = '0;
          acc_d   = '0;
          ph_d    = 1'b0;
          state_d = ST_TICK;
        end
      end

      ST_TICK: begin
        if (playing_q) begin
          state_d = ST_ANG_DIV;
        end else begin
          res_sample_d = '0;
          res_active_d = 1'b0;
          res_last_d   = 1'b0;
          state_d      = ST_EMIT;
        end
      end

      // angle = acc * 2^32 / rate, a fraction of a full turn
      ST_ANG_DIV: begin
        div_req_o.dividend = {acc_q, 32'b0};
        div_req_o.divisor  = rate_q;
        if (!ph_q) begin
          div_req_o.start = 1'b1;
          ph_d            = 1'b1;
        end else if (div_rsp_i.done) begin
          x_d     = angle[30] ? (Q30_ONE[30:0] - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};
          neg_d   = angle[31];
          ph_d    = 1'b0;
          state_d = ST_SQ_MUL;
        end
      end

      ST_SQ_MUL: begin
        mul_a = MUL_W'(x_q);
        mul_b = MUL_W'(x_q);
        ph_d  = ~ph_q;
        if (ph_q) begin
          x2_d    = prod_q[60:30];
          t_d     = C9;
          k_d     = '0;
          state_d = ST_POLY_MUL;
        end
      end

      ST_POLY_MUL: begin
        mul_a = MUL_W'(x2_q);
        mul_b = t_q;
        ph_d  = ~ph_q;
        if (ph_q) begin
          t_d = poly_coef(k_q) - prod_q[61:30];
          k_d = k_q + 1'b1;
          if (k_q == 2'(POLY_TERMS - 1)) begin
            state_d = ST_Y_MUL;
          end
        end
      end

      ST_Y_MUL: begin
        mul_a = MUL_W'(x_q);
        mul_b = t_q;
        ph_d  = ~ph_q;
        if (ph_q) begin
          s_d     = (prod_q[63:60] != '0) ? '1 : prod_q[59:45];
          state_d = ST_ENV_DIV;
        end
      end

      ST_ENV_DIV: begin
        div_req_o.dividend = DIV_W'(env_num) << ENV_W;
        div_req_o.divisor  = DIVISOR_W'(fade_q);
        if (!ph_q) begin
          if (fade_q != '0 && (rise_w || fall_w)) begin
            div_req_o.start = 1'b1;
            ph_d            = 1'b1;
          end else begin
            env_d   = '1;
            state_d = ST_AMP_MUL;
          end
        end else if (div_rsp_i.done) begin
          env_d   = (div_rsp_i.quotient[DIV_W-1:ENV_W] != '0) ? '1
                                                              : div_rsp_i.quotient[ENV_W-1:0];
          ph_d    = 1'b0;
          state_d = ST_AMP_MUL;
        end
      end

      ST_AMP_MUL: begin
        mul_a = MUL_W'(peak_q);
        mul_b = MUL_W'(s_q);
        ph_d  = ~ph_q;
        if (ph_q) begin
          p1_d    = prod_q[29:0];
          state_d = ST_MAG_MUL;
        end
      end

      ST_MAG_MUL: begin
        mul_a = MUL_W'(p1_q);
        mul_b = MUL_W'(env_q);
        ph_d  = ~ph_q;
        if (ph_q) begin
          res_sample_d = neg_q ? (SAMPLE_W'(0) - {1'b0, mag}) : {1'b0, mag};
          res_active_d = 1'b1;
          res_last_d   = last_w;
          acc_d        = (rate_q != '0 && acc_sum >= {1'b0, rate_q}) ? acc_wrap[PHASE_W-1:0]
                                                                    : acc_sum[PHASE_W-1:0];
          idx_d        = idx_inc[IW-1:0];
          if (last_w) begin
            playing_d = 1'b0;
          end
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_sample_d = res_sample_q;
          out_active_d = res_active_q;
          out_last_d   = res_last_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
        ph_d    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ph_q         <= 1'b0;
      rate_q       <= RATE_RESET;
      peak_q       <= PEAK_RESET;
      item_q       <= '0;
      idx_q        <= '0;
      tone_q       <= '0;
      fade_q       <= '0;
      acc_q        <= '0;
      step_q       <= '0;
      playing_q    <= 1'b0;
      x_q          <= '0;
      x2_q         <= '0;
      neg_q        <= 1'b0;
      t_q          <= '0;
      k_q          <= '0;
      s_q          <= '0;
      env_q        <= '0;
      p1_q         <= '0;
      res_sample_q <= '0;
      res_active_q <= 1'b0;
      res_last_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_active_q <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      ph_q         <= ph_d;
      rate_q       <= rate_d;
      peak_q       <= peak_d;
      item_q       <= item_d;
      idx_q        <= idx_d;
      tone_q       <= tone_d;
      fade_q       <= fade_d;
      acc_q        <= acc_d;
      step_q       <= step_d;
      playing_q    <= playing_d;
      x_q          <= x_d;
      x2_q         <= x2_d;
      neg_q        <= neg_d;
      t_q          <= t_d;
      k_q          <= k_d;
      s_q          <= s_d;
      env_q        <= env_d;
      p1_q         <= p1_d;
      res_sample_q <= res_sample_d;
      res_active_q <= res_active_d;
      res_last_q   <= res_last_d;
      out_valid_q  <= out_valid_d;
      out_sample_q <= out_sample_d;
      out_active_q <= out_active_d;
      out_last_q   <= out_last_d;
    end
  end

  // shared multiplier, product registered
  always_ff @(posedge clk_i) begin
    prod_q <= (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = $signed(out_sample_q);
  assign active_o    = out_active_q;
  assign last_o      = out_last_q;

  a_play_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    playing_q |-> (tone_q != '0))
    else $error("playing with zero tone length");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("result word not presented");

  a_silent_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_active_q) |-> (out_sample_q == '0 && !out_last_q))
    else $error("silent word carries data");

  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q != ST_IDLE))
    else $error("popped word not taken up");

endmodule

// ===== tb/tb_sine_tone_generator_with_fade_top.sv =====
// ----------------------------------------------------------------------------
// tb_sine_tone_generator_with_fade_top
// Drives sample ticks and register writes into the tone generator, predicts
// every output word with a bit-accurate fixed-point tone model and compares
// it field by field, under random idling on both sides and a long output hold.
// ----------------------------------------------------------------------------

localparam longint unsigned IDX_MASK = (64'd1 << stgf_pkg::INDEX_WIDTH_DEF) - 64'd1;

typedef struct packed {
  logic [15:0] sample;
  logic        active;
  logic        last;
} tone_word_t;

class tone_sample_board;
  longint unsigned rate;
  longint unsigned peak;
  longint unsigned idx;
  longint unsigned len;
  longint unsigned fade;
  longint unsigned acc;
  longint unsigned step;
  bit playing;
  tone_word_t expected_samples[$];
  int unsigned n_errors;

  function new();
    rate = stgf_pkg::RATE_RESET;
    peak = stgf_pkg::PEAK_RESET;
    idx = 0;
    len = 0;
    fade = 0;
    acc = 0;
    step = 0;
    playing = 0;
    n_errors = 0;
  endfunction

  function void set_reg(stgf_pkg::cfg_reg_e r, logic [15:0] v);
    case (r)
      stgf_pkg::REG_SAMPLE_RATE: begin
        rate = v;
      end
      stgf_pkg::REG_PEAK_AMPLITUDE: begin
        peak = v[14:0];
      end
      default: begin
      end
    endcase
  endfunction

  function longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // quarter-wave odd polynomial, sign from the quadrant
  function longint unsigned sine_mag(input longint unsigned turn, output bit neg);
    longint unsigned one, quad, r, x, x2, t, y;
    one = stgf_pkg::Q30_ONE;
    quad = (turn >> 30) & 64'd3;
    r = turn & (one - 64'd1);
    x = quad[0] ? (one - r) : r;
    x2 = q30_mul(x, x);
    t = stgf_pkg::C9;
    t = stgf_pkg::C7 - q30_mul(x2, t);
    t = stgf_pkg::C5 - q30_mul(x2, t);
    t = stgf_pkg::C3 - q30_mul(x2, t);
    t = stgf_pkg::C1 - q30_mul(x2, t);
    y = q30_mul(x, t) >> 15;
    if (y > 64'd32767) begin
      y = 64'd32767;
    end
    neg = (quad >= 64'd2);
    return y;
  endfunction

  function longint unsigned envelope();
    longint unsigned e;
    e = 64'd65535;
    if (fade != 0) begin
      if (idx < fade) begin
        e = (idx << 16) / fade;
      end
      // fall wins over rise
      if (len >= fade && idx > len - fade) begin
        e = ((len - idx) << 16) / fade;
      end
    end
    if (e > 64'd65535) begin
      e = 64'd65535;
    end
    return e;
  endfunction

  function tone_word_t next_sample(logic start, logic [14:0] freq, logic [15:0] dur);
    tone_word_t w;
    longint unsigned fr, dl, fd, turn, s, env, mag, nxt, neg_val;
    bit neg;
    w = '0;
    fr = freq;
    dl = dur;
    if (start) begin
      dl = rate * dl / stgf_pkg::MS_PER_S;
      len = (dl > IDX_MASK) ? IDX_MASK : dl;
      fd = rate / stgf_pkg::FADE_DIV;
      fade = (fd > 64'd255) ? 64'd255 : fd;
      idx = 0;
      acc = 0;
      step = (rate != 0) ? (fr % rate) : 64'd0;
      playing = (len != 0);
    end
    if (playing) begin
      turn = 0;
      if (rate != 0) begin
        turn = ((acc << 32) / rate) & 64'hFFFF_FFFF;
      end
      s = sine_mag(turn, neg);
      env = envelope();
      mag = (peak * s * env) >> 31;
      neg_val = (64'h1_0000 - mag) & 64'hFFFF;
      w.sample = neg ? neg_val[15:0] : mag[15:0];
      w.active = 1'b1;
      w.last = (idx + 64'd1 >= len);
      // a rate lowered mid-tone may leave the phase above it; one subtract only
      nxt = acc + step;
      if (rate != 0 && nxt >= rate) begin
        nxt = nxt - rate;
      end
      acc = nxt & 64'hFFFF;
      idx = (idx + 64'd1) & IDX_MASK;
      if (w.last) begin
        playing = 0;
      end
    end
    return w;
  endfunction

  function void note_tick(logic start, logic [14:0] freq, logic [15:0] dur);
    expected_samples.push_back(next_sample(start, freq, dur));
  endfunction

  function void report(string what, int exp_v, int act_v);
    n_errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
  endfunction

  function void check_word(logic [15:0] s, logic a, logic l);
    tone_word_t e;
    if (expected_samples.size() == 0) begin
      n_errors++;
      $display("%0t: unexpected word, expected none, actual sample %0d active %0b last %0b",
               $time, $signed(s), a, l);
      return;
    end
    e = expected_samples.pop_front();
    if (s !== e.sample) begin
      report("sample", $signed(e.sample), $signed(s));
    end
    if (a !== e.active) begin
      report("active", e.active, a);
    end
    if (l !== e.last) begin
      report("last", e.last, l);
    end
  endfunction

  function int pending();
    return expected_samples.size();
  endfunction
endclass

module tb_sine_tone_generator_with_fade_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned SETTLE_CYCLES = 100;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 cfg_valid_i;
  logic                                 cfg_ready_o;
  stgf_pkg::cfg_reg_e                   cfg_index_i;
  logic [stgf_pkg::CFG_DATA_W-1:0]      cfg_data_i;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic                                 start_req_i;
  logic [stgf_pkg::FREQ_W-1:0]          freq_hz_i;
  logic [stgf_pkg::DUR_W-1:0]           duration_ms_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic signed [stgf_pkg::SAMPLE_W-1:0] sample_o;
  logic                                 active_o;
  logic                                 last_o;

  tone_sample_board sb;
  bit no_idle;
  int unsigned hold_asks;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned cycle_cnt;

  sine_tone_generator_with_fade_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_req_i  (start_req_i),
    .freq_hz_i    (freq_hz_i),
    .duration_ms_i(duration_ms_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_o     (sample_o),
    .active_o     (active_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // output side: random stalls, plus a long hold when asked
  initial begin
    out_ready_i <= 1'b0;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_served < hold_asks) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(sample_o, active_o, last_o);
    end
  end

  task automatic send_tick(input logic start, input logic [14:0] freq, input logic [15:0] dur);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 22) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    start_req_i <= start;
    freq_hz_i <= freq;
    duration_ms_i <= dur;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(start, freq, dur);
  endtask

  // leaves valid high so a following write goes out back to back
  task automatic write_reg(input stgf_pkg::cfg_reg_e r, input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(r, v);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] rate, input logic [15:0] peak);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(stgf_pkg::REG_SAMPLE_RATE, rate);
      write_reg(stgf_pkg::REG_PEAK_AMPLITUDE, peak);
    end else begin
      write_reg(stgf_pkg::REG_PEAK_AMPLITUDE, peak);
      write_reg(stgf_pkg::REG_SAMPLE_RATE, rate);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_duration();
    logic [15:0] d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: d = 16'($urandom_range(0, 4));
      5, 6, 7:       d = 16'($urandom_range(5, 20));
      default:       d = 16'($urandom);
    endcase
    return d;
  endfunction

  function automatic logic [14:0] pick_freq();
    logic [14:0] f;
    if ($urandom_range(0, 3) == 0) begin
      f = 15'($urandom);
    end else begin
      f = 15'($urandom_range(0, 24000));
    end
    return f;
  endfunction

  // mostly running tones with short restarts; the last word leaves a long
  // tone playing into the next settings
  task automatic run_phase(input int n, input int start_pct);
    int i;
    for (i = 0; i < n - 1; i++) begin
      send_tick($urandom_range(0, 99) < start_pct, pick_freq(), pick_duration());
    end
    send_tick(1'b1, pick_freq(), 16'hFFFF);
  endtask

  initial begin
    int p;
    logic [15:0] rate;
    logic [15:0] peak;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= stgf_pkg::REG_SAMPLE_RATE;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    start_req_i <= 1'b0;
    freq_hz_i <= '0;
    duration_ms_i <= '0;
    no_idle = 0;
    hold_asks = 0;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings
    send_tick(1'b0, 15'h7FFF, 16'hFFFF);
    send_tick(1'b1, 15'h7FFF, 16'd0);     // zero length stays idle
    send_tick(1'b0, 15'd0, 16'd0);
    send_tick(1'b1, 15'd5512, 16'd1);     // shorter than the fade
    repeat (3) send_tick(1'b0, 15'($urandom), 16'($urandom));
    send_tick(1'b1, 15'd24000, 16'hFFFF); // restart while playing
    repeat (3) send_tick(1'b0, 15'($urandom), 16'($urandom));
    send_tick(1'b1, 15'h7FFF, 16'd2);     // freq above the rate
    repeat (2) send_tick(1'b0, 15'($urandom), 16'($urandom));
    send_tick(1'b1, 15'd11025, 16'd1);
    repeat (4) send_tick(1'b0, 15'($urandom), 16'($urandom));

    run_phase(70, 4);
    for (p = 0; p < 9; p++) begin
      case (p)
        0:       begin rate = 16'd8000;  peak = 16'd32767; end
        1:       begin rate = 16'd48000; peak = 16'd0;     end
        2:       begin rate = 16'd0;     peak = 16'd20000; end
        3:       begin rate = 16'hFFFF;  peak = 16'hFFFF;  end
        4:       begin rate = 16'd1;     peak = 16'd1;     end
        5:       begin rate = 16'd44100; peak = 16'h8000;  end
        6:       begin rate = 16'd16000; peak = 16'd32767; end
        default: begin
          rate = 16'($urandom_range(8000, 48000));
          peak = 16'($urandom_range(0, 32767));
        end
      endcase
      settle();
      set_config(rate, peak);
      no_idle = (p == 3);
      if (p == 1 || p == 6) begin
        hold_asks++;
      end
      run_phase(80, (p == 4) ? 20 : 4);
    end
    no_idle = 0;

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
